### hw/rtl/cbmsi_pkg.sv
`default_nettype none

package cbmsi_pkg;

    // Item kinds carried in the mode field
    typedef enum logic [1:0] {
        MODE_CPU_WRITE  = 2'd0,
        MODE_SCANLINE   = 2'd1,
        MODE_PRG_LOOKUP = 2'd2,
        MODE_CHR_LOOKUP = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode       mode;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [8:0]  scanline;
    } t_in_word;

    typedef struct packed {
        logic        irq_line;
        logic        mirroring;
        logic [18:0] rom_address;
        logic        address_hit;
    } t_out_word;

    typedef struct packed {
        logic       has_irq;
        logic [4:0] prg_size_log2;
        logic [4:0] chr_size_log2;
    } t_cfg;

    // Configuration register indexes
    localparam logic [1:0] CFG_HAS_IRQ       = 2'd0;
    localparam logic [1:0] CFG_PRG_SIZE_LOG2 = 2'd1;
    localparam logic [1:0] CFG_CHR_SIZE_LOG2 = 2'd2;

    localparam logic [4:0] SIZE_LOG2_RESET   = 5'd17;
    localparam logic [4:0] PRG_LOG2_MIN      = 5'd13;
    localparam logic [4:0] PRG_LOG2_MAX      = 5'd19;
    localparam logic [4:0] CHR_LOG2_MIN      = 5'd10;
    localparam logic [4:0] CHR_LOG2_MAX      = 5'd19;

    localparam logic [8:0] SCANLINE_LIMIT    = 9'd240;

    // CPU register decode
    localparam logic [15:0] DECODE_MASK_IRQ   = 16'hE003;
    localparam logic [15:0] DECODE_MASK_PLAIN = 16'hA003;
    localparam logic [15:0] ADDR_PRG0         = 16'h8000;
    localparam logic [15:0] ADDR_PRG1         = 16'h8001;
    localparam logic [15:0] ADDR_CHR2K0       = 16'h8002;
    localparam logic [15:0] ADDR_CHR2K1       = 16'h8003;
    localparam logic [15:0] ADDR_CHR1K0       = 16'hA000;
    localparam logic [15:0] ADDR_CHR1K1       = 16'hA001;
    localparam logic [15:0] ADDR_CHR1K2       = 16'hA002;
    localparam logic [15:0] ADDR_CHR1K3       = 16'hA003;
    localparam logic [15:0] ADDR_IRQ_LATCH    = 16'hC000;
    localparam logic [15:0] ADDR_IRQ_RELOAD   = 16'hC001;
    localparam logic [15:0] ADDR_IRQ_ENABLE   = 16'hC002;
    localparam logic [15:0] ADDR_IRQ_DISABLE  = 16'hC003;
    localparam logic [15:0] ADDR_MIRROR       = 16'hE000;

    localparam logic [5:0]  PRG_SEL_MASK      = 6'h3F;

    function automatic logic [4:0] clamp_log2(input logic [4:0] v,
                                              input logic [4:0] lo,
                                              input logic [4:0] hi);
        logic [4:0] r;
        r = v;
        if (v < lo) r = lo;
        else if (v > hi) r = hi;
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/cartridge_bank_mapper_scanline_irq_unit.sv
// Cartridge bank mapper with optional scanline interrupt.
// Input channel (i_in_valid / o_in_stall / i_in_word) takes one word per item:
// a CPU register write, a scanline tick, a program lookup or a pattern lookup.
// Output channel (o_out_valid / i_out_stall / o_out_word) returns exactly one
// word per item, in order: IRQ level and mirroring bit after the item, and the
// translated ROM byte address with a hit flag for lookups.
// The item's bank state update and translation are one combinational pass from
// the input port into the result register.
// Throughput is one item per clock while the receiver takes words; the rate is
// set by that single pass and the one-word output register.
// When the receiver stalls, the held result stays on o_out_word and one more
// word lands in a skid register; o_in_stall rises only while the skid is full.
// Configuration (i_cfg_wr_en, i_cfg_index, i_cfg_data) writes has_irq and the
// program / pattern ROM size; write it only while the block is idle.
// Synchronous reset clears all bank selects and IRQ state, sets both ROM sizes
// to 128 KiB, selects the plain variant and empties both output stages.
`default_nettype none

module cartridge_bank_mapper_scanline_irq_unit (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [4:0]           i_cfg_data,
    input  wire logic                 i_in_valid,
    input  wire cbmsi_pkg::t_in_word  i_in_word,
    output logic                      o_in_stall,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output cbmsi_pkg::t_out_word      o_out_word
);
    import cbmsi_pkg::*;

    t_cfg      r_cfg;
    t_out_word r_out;
    t_out_word r_skid;
    logic      r_out_valid;
    logic      r_skid_valid;

    t_out_word result;
    logic      in_accept;
    logic      out_free;

    // Accept whenever the skid is empty; the output register drains it first
    assign in_accept = i_in_valid && !r_skid_valid;
    assign out_free  = !r_out_valid || !i_out_stall;

    cbmsi_mapper u_mapper (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in_word),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    // Configuration registers; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.has_irq       <= 1'b0;
            r_cfg.prg_size_log2 <= SIZE_LOG2_RESET;
            r_cfg.chr_size_log2 <= SIZE_LOG2_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_HAS_IRQ:       r_cfg.has_irq       <= i_cfg_data[0];
                CFG_PRG_SIZE_LOG2: r_cfg.prg_size_log2 <= i_cfg_data;
                CFG_CHR_SIZE_LOG2: r_cfg.chr_size_log2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Output register and skid: control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            // Advance the skid word first; no new word is taken in that cycle
            r_out_valid  <= r_skid_valid || in_accept;
            r_skid_valid <= 1'b0;
        end else if (in_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Output register and skid: payload
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : result;
        end else if (in_accept) begin
            r_skid <= result;
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

`default_nettype wire

### hw/rtl/cbmsi_mapper.sv
`default_nettype none

module cbmsi_mapper (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire cbmsi_pkg::t_in_word i_item,
    input  wire cbmsi_pkg::t_cfg    i_cfg,
    output cbmsi_pkg::t_out_word    o_result
);
    import cbmsi_pkg::*;

    logic [5:0] r_prg_sel [2];
    logic [7:0] r_chr2k_sel [2];
    logic [7:0] r_chr1k_sel [4];
    logic       r_mirror;
    logic [7:0] r_irq_latch;
    logic [7:0] r_irq_count;
    logic       r_irq_enable;
    logic       r_irq_reload;
    logic       r_irq_pending;

    logic [5:0] n_prg_sel [2];
    logic [7:0] n_chr2k_sel [2];
    logic [7:0] n_chr1k_sel [4];
    logic       n_mirror;
    logic [7:0] n_irq_latch;
    logic [7:0] n_irq_count;
    logic       n_irq_enable;
    logic       n_irq_reload;
    logic       n_irq_pending;

    logic [4:0]  prg_log2;
    logic [4:0]  chr_log2;
    logic [2:0]  prg_shift;
    logic [5:0]  prg_mask;
    logic [5:0]  prg_bank;
    logic [18:0] chr_mask;
    logic [18:0] chr_full;
    logic [15:0] dec_irq;
    logic [15:0] dec_plain;
    logic [7:0]  wd;

    // Bank translation
    always_comb begin
        prg_log2  = clamp_log2(i_cfg.prg_size_log2, PRG_LOG2_MIN, PRG_LOG2_MAX);
        chr_log2  = clamp_log2(i_cfg.chr_size_log2, CHR_LOG2_MIN, CHR_LOG2_MAX);
        prg_shift = 3'(prg_log2 - PRG_LOG2_MIN);
        prg_mask  = 6'((7'd1 << prg_shift) - 7'd1);
        chr_mask  = 19'((20'd1 << chr_log2) - 20'd1);
        case (i_item.address[14:13])
            2'd0:    prg_bank = r_prg_sel[0];
            2'd1:    prg_bank = r_prg_sel[1];
            2'd2:    prg_bank = prg_mask & 6'b111110;   // second-to-last, or 0
            default: prg_bank = prg_mask;               // last bank
        endcase
        prg_bank = prg_bank & prg_mask;
        if (!i_item.address[12]) begin
            chr_full = {r_chr2k_sel[i_item.address[11]], i_item.address[10:0]};
        end else begin
            chr_full = {1'b0, r_chr1k_sel[i_item.address[11:10]], i_item.address[9:0]};
        end
    end

    // Next state
    always_comb begin
        n_prg_sel     = r_prg_sel;
        n_chr2k_sel   = r_chr2k_sel;
        n_chr1k_sel   = r_chr1k_sel;
        n_mirror      = r_mirror;
        n_irq_latch   = r_irq_latch;
        n_irq_count   = r_irq_count;
        n_irq_enable  = r_irq_enable;
        n_irq_reload  = r_irq_reload;
        n_irq_pending = r_irq_pending;
        wd            = i_item.write_data;
        dec_irq       = i_item.address & DECODE_MASK_IRQ;
        dec_plain     = i_item.address & DECODE_MASK_PLAIN;
        if (i_accept) begin
            case (i_item.mode)
                MODE_CPU_WRITE: begin
                    if (i_cfg.has_irq) begin
                        case (dec_irq)
                            ADDR_PRG0:        n_prg_sel[0] = wd[5:0] & PRG_SEL_MASK;
                            ADDR_PRG1:        n_prg_sel[1] = wd[5:0] & PRG_SEL_MASK;
                            ADDR_CHR2K0:      n_chr2k_sel[0] = wd;
                            ADDR_CHR2K1:      n_chr2k_sel[1] = wd;
                            ADDR_CHR1K0, ADDR_CHR1K1, ADDR_CHR1K2, ADDR_CHR1K3:
                                n_chr1k_sel[i_item.address[1:0]] = wd;
                            ADDR_IRQ_LATCH:   n_irq_latch = wd;
                            ADDR_IRQ_RELOAD: begin
                                n_irq_count  = '0;
                                n_irq_reload = 1'b1;
                            end
                            ADDR_IRQ_ENABLE:  n_irq_enable = 1'b1;
                            ADDR_IRQ_DISABLE: begin
                                n_irq_enable  = 1'b0;
                                n_irq_pending = 1'b0;
                            end
                            ADDR_MIRROR:      n_mirror = wd[6];
                            default: ;
                        endcase
                    end else begin
                        case (dec_plain)
                            ADDR_PRG0: begin
                                n_mirror     = wd[6];
                                n_prg_sel[0] = wd[5:0] & PRG_SEL_MASK;
                            end
                            ADDR_PRG1:   n_prg_sel[1] = wd[5:0] & PRG_SEL_MASK;
                            ADDR_CHR2K0: n_chr2k_sel[0] = wd;
                            ADDR_CHR2K1: n_chr2k_sel[1] = wd;
                            ADDR_CHR1K0, ADDR_CHR1K1, ADDR_CHR1K2, ADDR_CHR1K3:
                                n_chr1k_sel[i_item.address[1:0]] = wd;
                            default: ;
                        endcase
                    end
                end
                MODE_SCANLINE: begin
                    if (i_cfg.has_irq && (i_item.scanline < SCANLINE_LIMIT)) begin
                        if ((r_irq_count == 8'd0) || r_irq_reload) begin
                            n_irq_count  = r_irq_latch;
                            n_irq_reload = 1'b0;
                        end else begin
                            n_irq_count = r_irq_count - 8'd1;
                        end
                        if ((n_irq_count == 8'd0) && r_irq_enable) n_irq_pending = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Result word for the item being accepted
    always_comb begin
        o_result             = '0;
        o_result.irq_line    = n_irq_pending;
        o_result.mirroring   = n_mirror;
        case (i_item.mode)
            MODE_PRG_LOOKUP: begin
                if (i_item.address[15]) begin
                    o_result.rom_address = {prg_bank, i_item.address[12:0]};
                    o_result.address_hit = 1'b1;
                end
            end
            MODE_CHR_LOOKUP: begin
                if (i_item.address[15:13] == 3'd0) begin
                    o_result.rom_address = chr_full & chr_mask;
                    o_result.address_hit = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_sel     <= '{default: '0};
            r_chr2k_sel   <= '{default: '0};
            r_chr1k_sel   <= '{default: '0};
            r_mirror      <= 1'b0;
            r_irq_latch   <= '0;
            r_irq_count   <= '0;
            r_irq_enable  <= 1'b0;
            r_irq_reload  <= 1'b0;
            r_irq_pending <= 1'b0;
        end else begin
            r_prg_sel     <= n_prg_sel;
            r_chr2k_sel   <= n_chr2k_sel;
            r_chr1k_sel   <= n_chr1k_sel;
            r_mirror      <= n_mirror;
            r_irq_latch   <= n_irq_latch;
            r_irq_count   <= n_irq_count;
            r_irq_enable  <= n_irq_enable;
            r_irq_reload  <= n_irq_reload;
            r_irq_pending <= n_irq_pending;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/cbmsi_checker.sv
`default_nettype none

module cbmsi_checker (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire cbmsi_pkg::t_in_word  i_in_word,
    input  wire logic                 o_in_stall,
    input  wire logic                 o_out_valid,
    input  wire logic                 i_out_stall,
    input  wire cbmsi_pkg::t_out_word o_out_word
);
    import cbmsi_pkg::*;

    // Output is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid after reset");

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled output word changed");

    // Input back-pressure only when a result already waits
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output");

    // A word accepted into an empty output shows up in the next cycle
    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !o_out_valid |=> o_out_valid)
        else $error("accepted word not delivered after one cycle");

    // Writes and ticks accepted into an empty output report no translated address
    a_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !o_out_valid &&
        ((i_in_word.mode == MODE_CPU_WRITE) || (i_in_word.mode == MODE_SCANLINE))
        |=> !o_out_word.address_hit && (o_out_word.rom_address == '0))
        else $error("hit reported for a non-lookup word");

endmodule

bind cartridge_bank_mapper_scanline_irq_unit cbmsi_checker u_cbmsi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_word   (i_in_word),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

`default_nettype wire
